[rtl/rgbfc_pkg.sv]
// shared types, constants and pixel functions for the rgb565 false color box overlay
package rgbfc_pkg;

    localparam int PIX_W    = 16;
    localparam int CFG_W    = 13;
    localparam int CFG_IDX_W = 3;

    localparam logic [PIX_W-1:0] BOX_GREEN = 16'h07E0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THERMAL_ON   = 3'd0,
        REG_BOX_ON       = 3'd1,
        REG_BOX_LEFT     = 3'd2,
        REG_BOX_TOP      = 3'd3,
        REG_BOX_WIDTH    = 3'd4,
        REG_BOX_HEIGHT   = 3'd5,
        REG_FRAME_WIDTH  = 3'd6,
        REG_FRAME_HEIGHT = 3'd7
    } t_cfg_reg;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd320;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd240;

    // ramp segments, 64 levels each
    typedef enum logic [1:0] {
        SEG_BLUE   = 2'd0,
        SEG_CYAN   = 2'd1,
        SEG_YELLOW = 2'd2,
        SEG_RED    = 2'd3
    } t_ramp_seg;

    function automatic logic [7:0] luma_of(input logic [PIX_W-1:0] p);
        logic [7:0]  r8;
        logic [7:0]  g8;
        logic [7:0]  b8;
        logic [15:0] sum;
        r8  = {p[15:11], 3'b000};
        g8  = {p[10:5], 2'b00};
        b8  = {p[4:0], 3'b000};
        sum = 16'(r8) * 16'd77 + 16'(g8) * 16'd150 + 16'(b8) * 16'd29;
        return sum[15:8];
    endfunction

    function automatic logic [PIX_W-1:0] ramp_color(input logic [7:0] lvl);
        logic [7:0] off;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        off = {lvl[5:0], 2'b00};
        case (t_ramp_seg'(lvl[7:6]))
            SEG_BLUE: begin
                r = 8'd0;   g = 8'd0;         b = off;
            end
            SEG_CYAN: begin
                r = 8'd0;   g = off;          b = 8'd255;
            end
            SEG_YELLOW: begin
                r = off;    g = 8'd255;       b = 8'd255 - off;
            end
            SEG_RED: begin
                r = 8'd255; g = 8'd255 - off; b = 8'd0;
            end
            default: begin
                r = 8'd0;   g = 8'd0;         b = 8'd0;
            end
        endcase
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

endpackage

[rtl/rgbfc_if.sv]
// stream and configuration interfaces of the rgb565 false color box overlay
interface rgbfc_in_if import rgbfc_pkg::*; #(
    parameter int COORD_BITS = 12
) ();
    logic                  valid;
    logic                  ready;
    logic [PIX_W-1:0]      pixel_in;
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;

    modport source (output valid, output pixel_in, output col, output row, input ready);
    modport sink   (input valid, input pixel_in, input col, input row, output ready);
endinterface

interface rgbfc_out_if import rgbfc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_out;

    modport source (output valid, output pixel_out, input ready);
    modport sink   (input valid, input pixel_out, output ready);
endinterface

interface rgbfc_cfg_if import rgbfc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/rgb565_false_color_box_overlay.sv]
// rgb565 false color and detection box overlay stage
//
// i_pix carries one rgb565 pixel with its column and row per transaction,
// o_pix returns one processed pixel per transaction, in order.
// i_cfg writes one register per transaction (index, data) and is always
// ready; write it only while no pixel is in flight.
// The false color ramp (luma, four 64-level segments) is applied first when
// thermal_on is set, then the two-pixel green border overwrites when box_on
// is set. Pixels outside the frame pass through untouched.
// The path is an input register, then the ramp and border logic into the
// output register. Throughput is one pixel per cycle while o_pix does not
// stall, set by the two register stages.
// A stall on o_pix holds the output register; the input register still
// fills, so i_pix drops ready only once both stages hold a pixel.
// Synchronous reset empties both stages and returns the registers to their
// defaults (frame 320 x 240, effects off, box zero).
module rgb565_false_color_box_overlay import rgbfc_pkg::*; #(
    parameter int COORD_BITS = 12
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rgbfc_in_if.sink     i_pix,
    rgbfc_out_if.source  o_pix,
    rgbfc_cfg_if.sink    i_cfg
);

    // signed work width holding coordinates and the box arithmetic
    localparam int W = ((COORD_BITS > CFG_W + 1) ? COORD_BITS : CFG_W + 1) + 2;

    logic                  r_thermal_on;
    logic                  r_box_on;
    logic [CFG_W-1:0]      r_box_left;
    logic [CFG_W-1:0]      r_box_top;
    logic [CFG_W-1:0]      r_box_width;
    logic [CFG_W-1:0]      r_box_height;
    logic [CFG_W-1:0]      r_frame_width;
    logic [CFG_W-1:0]      r_frame_height;

    logic                  r_in_valid;
    logic [PIX_W-1:0]      r_in_pix;
    logic [COORD_BITS-1:0] r_in_col;
    logic [COORD_BITS-1:0] r_in_row;

    logic                  r_out_valid;
    logic [PIX_W-1:0]      r_out_pix;
    logic [PIX_W-1:0]      n_out_pix;

    logic                  out_adv;
    logic                  in_adv;

    logic signed [W-1:0]   c;
    logic signed [W-1:0]   r;
    logic signed [W-1:0]   left;
    logic signed [W-1:0]   top;
    logic signed [W-1:0]   fw;
    logic signed [W-1:0]   fh;
    logic signed [W-1:0]   x1;
    logic signed [W-1:0]   y1;
    logic signed [W-1:0]   x2;
    logic signed [W-1:0]   y2;
    logic signed [W-1:0]   x2_raw;
    logic signed [W-1:0]   y2_raw;
    logic                  in_frame;
    logic                  on_row_band;
    logic                  on_col_band;
    logic                  on_border;

    assign out_adv     = !r_out_valid || o_pix.ready;
    assign in_adv      = !r_in_valid || out_adv;
    assign i_pix.ready = in_adv;
    assign i_cfg.ready = 1'b1;

    assign o_pix.valid     = r_out_valid;
    assign o_pix.pixel_out = r_out_pix;

    // box geometry, all in signed work width
    always_comb begin
        c      = $signed({{(W-COORD_BITS){1'b0}}, r_in_col});
        r      = $signed({{(W-COORD_BITS){1'b0}}, r_in_row});
        left   = $signed({{(W-CFG_W){r_box_left[CFG_W-1]}}, r_box_left});
        top    = $signed({{(W-CFG_W){r_box_top[CFG_W-1]}}, r_box_top});
        fw     = $signed({{(W-CFG_W){1'b0}}, r_frame_width});
        fh     = $signed({{(W-CFG_W){1'b0}}, r_frame_height});
        x1     = left[W-1] ? '0 : left;
        y1     = top[W-1] ? '0 : top;
        x2_raw = left + $signed({{(W-CFG_W){1'b0}}, r_box_width}) - W'(1);
        y2_raw = top + $signed({{(W-CFG_W){1'b0}}, r_box_height}) - W'(1);
        x2     = (x2_raw >= fw) ? fw - W'(1) : x2_raw;
        y2     = (y2_raw >= fh) ? fh - W'(1) : y2_raw;

        in_frame    = (c < fw) && (r < fh);
        on_row_band = (c >= x1) && (c <= x2) &&
                      ((r == y1) || (r == y1 + W'(1)) || (r == y2) || (r == y2 - W'(1)));
        on_col_band = (r >= y1) && (r <= y2) &&
                      ((c == x1) || (c == x1 + W'(1)) || (c == x2) || (c == x2 - W'(1)));
        on_border   = on_row_band || on_col_band;

        n_out_pix = r_in_pix;
        if (in_frame) begin
            if (r_thermal_on) begin
                n_out_pix = ramp_color(luma_of(r_in_pix));
            end
            if (r_box_on && on_border) begin
                n_out_pix = BOX_GREEN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thermal_on   <= 1'b0;
            r_box_on       <= 1'b0;
            r_box_left     <= '0;
            r_box_top      <= '0;
            r_box_width    <= '0;
            r_box_height   <= '0;
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else if (i_cfg.valid) begin
            case (t_cfg_reg'(i_cfg.index))
                REG_THERMAL_ON:   r_thermal_on   <= i_cfg.data[0];
                REG_BOX_ON:       r_box_on       <= i_cfg.data[0];
                REG_BOX_LEFT:     r_box_left     <= i_cfg.data;
                REG_BOX_TOP:      r_box_top      <= i_cfg.data;
                REG_BOX_WIDTH:    r_box_width    <= i_cfg.data;
                REG_BOX_HEIGHT:   r_box_height   <= i_cfg.data;
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg.data;
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_adv) begin
                r_in_valid <= i_pix.valid;
            end
            if (out_adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_adv && i_pix.valid) begin
            r_in_pix <= i_pix.pixel_in;
            r_in_col <= i_pix.col;
            r_in_row <= i_pix.row;
        end
        if (out_adv && r_in_valid) begin
            r_out_pix <= n_out_pix;
        end
    end

endmodule

[verif/tb_rgb565_false_color_box_overlay.sv]
// testbench for the rgb565 false color box overlay: directed table, random settings, pixel check
`timescale 1ns / 100ps

module tb_rgb565_false_color_box_overlay;
    import rgbfc_pkg::*;

    localparam int COORD_BITS  = 12;
    localparam int CYCLE_LIMIT = 100000;
    localparam int RAMP_STEP   = 64;
    localparam int N_PHASES    = 12;
    localparam int PHASE_ITEMS = 58;

    typedef struct {
        bit thermal;
        bit box;
        int left;
        int top;
        int bw;
        int bh;
        int fw;
        int fh;
    } t_overlay_cfg;

    typedef struct {
        int               prof;
        logic [PIX_W-1:0] pix;
        logic [11:0]      col;
        logic [11:0]      row;
        bit               typed;
        logic [PIX_W-1:0] want;
    } t_pix_row;

    logic i_clk;
    logic i_rst_n;

    rgbfc_in_if #(.COORD_BITS(COORD_BITS)) pix_if ();
    rgbfc_out_if                           res_if ();
    rgbfc_cfg_if                           cfg_if ();

    rgb565_false_color_box_overlay #(.COORD_BITS(COORD_BITS)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if.sink),
        .o_pix   (res_if.source),
        .i_cfg   (cfg_if.sink)
    );

    // register copies, reset values
    bit th_en   = 1'b0;
    bit bx_en   = 1'b0;
    int bx_left = 0;
    int bx_top  = 0;
    int bx_w    = 0;
    int bx_h    = 0;
    int frm_w   = int'(FRAME_WIDTH_RST);
    int frm_h   = int'(FRAME_HEIGHT_RST);

    logic [PIX_W-1:0] overlaid_pixels [$];
    int               mismatch_cnt = 0;
    int               cycle_cnt    = 0;
    bit               src_idle_on  = 1'b1;
    bit               snk_idle_on  = 1'b1;

    // profile 0 is the reset state and is never written
    t_overlay_cfg profiles [6] = '{
        '{1'b0, 1'b0, 0, 0, 0, 0, 320, 240},
        '{1'b1, 1'b1, 10, 20, 30, 40, 320, 240},
        '{1'b0, 1'b1, -4096, -4096, 4096, 4096, 4096, 4096},
        '{1'b1, 1'b1, 4095, 4095, 4096, 4096, 4096, 4096},
        '{1'b1, 1'b1, 0, 0, 10, 10, 0, 0},
        '{1'b0, 1'b1, 5, 5, 200, 1, 64, 48}
    };

    t_pix_row dir_rows [25] = '{
        '{0, 16'hFFFF, 12'd0,    12'd0,    1'b1, 16'hFFFF},
        '{0, 16'h0000, 12'd319,  12'd239,  1'b1, 16'h0000},
        '{0, 16'h1234, 12'd4095, 12'd4095, 1'b1, 16'h1234},
        '{1, 16'hFFFF, 12'd100,  12'd100,  1'b1, 16'hF8A0},
        '{1, 16'h0000, 12'd100,  12'd100,  1'b1, 16'h0000},
        '{1, 16'hABCD, 12'd10,   12'd20,   1'b1, 16'h07E0},
        '{1, 16'hABCD, 12'd39,   12'd59,   1'b1, 16'h07E0},
        '{1, 16'h1357, 12'd11,   12'd40,   1'b0, 16'h0000},
        '{1, 16'h8000, 12'd12,   12'd40,   1'b0, 16'h0000},
        '{1, 16'h07FF, 12'd25,   12'd21,   1'b0, 16'h0000},
        '{1, 16'hF81F, 12'd25,   12'd58,   1'b0, 16'h0000},
        '{1, 16'h5555, 12'd320,  12'd0,    1'b1, 16'h5555},
        '{1, 16'h4321, 12'd0,    12'd240,  1'b1, 16'h4321},
        '{1, 16'h001F, 12'd9,    12'd20,   1'b0, 16'h0000},
        '{2, 16'h2222, 12'd0,    12'd0,    1'b0, 16'h0000},
        '{2, 16'hFFFF, 12'd4095, 12'd4095, 1'b0, 16'h0000},
        '{3, 16'h0000, 12'd4095, 12'd4095, 1'b1, 16'h07E0},
        '{3, 16'h0000, 12'd4094, 12'd4095, 1'b0, 16'h0000},
        '{3, 16'hFFFF, 12'd0,    12'd0,    1'b1, 16'hF8A0},
        '{4, 16'hFFFF, 12'd0,    12'd0,    1'b1, 16'hFFFF},
        '{4, 16'h0000, 12'd4095, 12'd0,    1'b1, 16'h0000},
        '{5, 16'h1111, 12'd30,   12'd4,    1'b0, 16'h0000},
        '{5, 16'h1111, 12'd63,   12'd5,    1'b0, 16'h0000},
        '{5, 16'h1111, 12'd62,   12'd10,   1'b0, 16'h0000},
        '{5, 16'h1111, 12'd64,   12'd5,    1'b1, 16'h1111}
    };

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("** rgb565_false_color_box_overlay: FAILED **");
            $finish;
        end
    end

    function automatic logic [PIX_W-1:0] overlay_pixel(logic [PIX_W-1:0] pix,
                                                       logic [11:0] c, logic [11:0] r);
        int               ci;
        int               ri;
        int               lum;
        int               off;
        int               rr;
        int               gg;
        int               bb;
        int               x1;
        int               y1;
        int               x2;
        int               y2;
        bit               on_h;
        bit               on_v;
        logic [PIX_W-1:0] res;
        ci = int'(c);
        ri = int'(r);
        if (ci >= frm_w || ri >= frm_h)
            return pix;
        res = pix;
        if (th_en) begin
            lum = (77 * (int'(pix[15:11]) << 3) + 150 * (int'(pix[10:5]) << 2)
                   + 29 * (int'(pix[4:0]) << 3)) >> 8;
            off = (lum % RAMP_STEP) * 4;
            rr  = 0;
            gg  = 0;
            bb  = 0;
            case (t_ramp_seg'(lum / RAMP_STEP))
                SEG_BLUE: begin
                    bb = off;
                end
                SEG_CYAN: begin
                    gg = off;
                    bb = 255;
                end
                SEG_YELLOW: begin
                    rr = off;
                    gg = 255;
                    bb = 255 - off;
                end
                SEG_RED: begin
                    rr = 255;
                    gg = 255 - off;
                end
                default: begin
                end
            endcase
            res = {rr[7:3], gg[7:2], bb[7:3]};
        end
        if (bx_en) begin
            x1 = bx_left < 0 ? 0 : bx_left;
            y1 = bx_top < 0 ? 0 : bx_top;
            x2 = bx_left + bx_w - 1;
            y2 = bx_top + bx_h - 1;
            if (x2 >= frm_w) x2 = frm_w - 1;
            if (y2 >= frm_h) y2 = frm_h - 1;
            on_h = ci >= x1 && ci <= x2 &&
                   (ri == y1 || ri == y1 + 1 || ri == y2 || ri == y2 - 1);
            on_v = ri >= y1 && ri <= y2 &&
                   (ci == x1 || ci == x1 + 1 || ci == x2 || ci == x2 - 1);
            if (on_h || on_v) res = BOX_GREEN;
        end
        return res;
    endfunction

    // near the box edges or the frame edge, within the frame range, or anywhere
    function automatic logic [11:0] pick_coord(int lo, int hi, int span);
        int v;
        case ($urandom_range(9))
            0, 1: v = int'($urandom);
            2, 3, 4, 5: begin
                case ($urandom_range(2))
                    0: v = lo + int'($urandom_range(3)) - 1;
                    1: v = hi + int'($urandom_range(3)) - 2;
                    default: v = span - 1 + int'($urandom_range(1));
                endcase
            end
            default: v = int'($urandom_range(span + 2 > 4095 ? 4095 : span + 2));
        endcase
        return 12'(v);
    endfunction

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            REG_THERMAL_ON:   th_en   = val[0];
            REG_BOX_ON:       bx_en   = val[0];
            REG_BOX_LEFT:     bx_left = int'($signed(val));
            REG_BOX_TOP:      bx_top  = int'($signed(val));
            REG_BOX_WIDTH:    bx_w    = int'(val);
            REG_BOX_HEIGHT:   bx_h    = int'(val);
            REG_FRAME_WIDTH:  frm_w   = int'(val);
            REG_FRAME_HEIGHT: frm_h   = int'(val);
            default: begin
            end
        endcase
    endtask

    task automatic load_overlay_cfg(input t_overlay_cfg s);
        write_reg(REG_THERMAL_ON,   13'(s.thermal));
        write_reg(REG_BOX_ON,       13'(s.box));
        write_reg(REG_BOX_LEFT,     13'(s.left));
        write_reg(REG_BOX_TOP,      13'(s.top));
        write_reg(REG_BOX_WIDTH,    13'(s.bw));
        write_reg(REG_BOX_HEIGHT,   13'(s.bh));
        write_reg(REG_FRAME_WIDTH,  13'(s.fw));
        write_reg(REG_FRAME_HEIGHT, 13'(s.fh));
        cfg_if.valid <= 1'b0;
    endtask

    task automatic random_settings(output t_overlay_cfg s);
        s.thermal = 1'($urandom_range(1));
        s.box     = $urandom_range(3) != 0;
        s.fw      = 1 + int'($urandom_range(47));
        s.fh      = 1 + int'($urandom_range(47));
        s.left    = int'($urandom_range(s.fw + 8)) - 6;
        s.top     = int'($urandom_range(s.fh + 8)) - 6;
        s.bw      = int'($urandom_range(s.fw + 6));
        s.bh      = int'($urandom_range(s.fh + 6));
        case ($urandom_range(9))
            0: begin
                s.fw   = 1 + int'($urandom_range(4095));
                s.fh   = 1 + int'($urandom_range(4095));
                s.left = int'($urandom_range(8191)) - 4096;
                s.top  = int'($urandom_range(8191)) - 4096;
                s.bw   = int'($urandom_range(4096));
                s.bh   = int'($urandom_range(4096));
            end
            1: begin
                s.fw   = $urandom_range(1) ? 4096 : 1;
                s.fh   = $urandom_range(1) ? 4096 : 1;
                s.left = $urandom_range(1) ? -4096 : 4095;
                s.top  = $urandom_range(1) ? 4095 : -4096;
                s.bw   = $urandom_range(1) ? 4096 : 0;
                s.bh   = $urandom_range(1) ? 4096 : 1;
            end
            2: begin
                // empty frame: everything passes through
                if ($urandom_range(1)) s.fw = 0;
                else s.fh = 0;
            end
            default: ;
        endcase
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic [11:0] c,
                              input logic [11:0] r, input bit typed,
                              input logic [PIX_W-1:0] want);
        int gap;
        gap = src_idle_on ? int'($urandom_range(6)) : 0;
        if (gap > 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_if.valid    <= 1'b1;
        pix_if.pixel_in <= pix;
        pix_if.col      <= c;
        pix_if.row      <= r;
        do @(posedge i_clk); while (!pix_if.ready);
        overlaid_pixels.push_back(typed ? want : overlay_pixel(pix, c, r));
    endtask

    task automatic send_random_pixel();
        int               x1;
        int               y1;
        int               x2;
        int               y2;
        logic [PIX_W-1:0] pix;
        x1 = bx_left < 0 ? 0 : bx_left;
        y1 = bx_top < 0 ? 0 : bx_top;
        x2 = bx_left + bx_w - 1;
        y2 = bx_top + bx_h - 1;
        if (x2 >= frm_w) x2 = frm_w - 1;
        if (y2 >= frm_h) y2 = frm_h - 1;
        case ($urandom_range(7))
            0: pix = 16'h0000;
            1: pix = 16'hFFFF;
            default: pix = 16'($urandom);
        endcase
        send_pixel(pix, pick_coord(x1, x2, frm_w), pick_coord(y1, y2, frm_h), 1'b0, 16'h0000);
    endtask

    task automatic drain_pixels();
        pix_if.valid <= 1'b0;
        while (overlaid_pixels.size() != 0) @(posedge i_clk);
    endtask

    // result side: random stalls, compare each transaction with the oldest prediction
    initial begin
        int               stall;
        logic [PIX_W-1:0] want;
        res_if.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = snk_idle_on ? int'($urandom_range(6)) : 0;
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!res_if.valid);
            if (overlaid_pixels.size() == 0) begin
                $error("pixel_out with no transaction pending: got %h", res_if.pixel_out);
                mismatch_cnt++;
            end else begin
                want = overlaid_pixels.pop_front();
                if (res_if.pixel_out !== want) begin
                    $error("pixel_out mismatch: expected %h, got %h", want, res_if.pixel_out);
                    mismatch_cnt++;
                end
            end
        end
    end

    initial begin
        t_overlay_cfg s;
        int           cur_prof;
        int           ph;
        i_rst_n         <= 1'b0;
        pix_if.valid    <= 1'b0;
        pix_if.pixel_in <= '0;
        pix_if.col      <= '0;
        pix_if.row      <= '0;
        cfg_if.valid    <= 1'b0;
        cfg_if.index    <= REG_THERMAL_ON;
        cfg_if.data     <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        cur_prof = 0;
        foreach (dir_rows[k]) begin
            if (dir_rows[k].prof != cur_prof) begin
                drain_pixels();
                load_overlay_cfg(profiles[dir_rows[k].prof]);
                cur_prof    = dir_rows[k].prof;
                src_idle_on = $urandom_range(3) != 0;
                snk_idle_on = $urandom_range(3) != 0;
            end
            send_pixel(dir_rows[k].pix, dir_rows[k].col, dir_rows[k].row,
                       dir_rows[k].typed, dir_rows[k].want);
        end

        for (ph = 0; ph < N_PHASES; ph++) begin
            drain_pixels();
            random_settings(s);
            load_overlay_cfg(s);
            src_idle_on = $urandom_range(3) != 0;
            snk_idle_on = $urandom_range(3) != 0;
            repeat (PHASE_ITEMS) send_random_pixel();
        end

        drain_pixels();
        repeat (4) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("** rgb565_false_color_box_overlay: PASSED **");
        end else begin
            $display("** rgb565_false_color_box_overlay: FAILED **");
        end
        $finish;
    end

endmodule

[files.f]
rtl/rgbfc_pkg.sv
rtl/rgbfc_if.sv
rtl/rgb565_false_color_box_overlay.sv
verif/tb_rgb565_false_color_box_overlay.sv
